FILE: sv/hrsp_pkg.sv
// Package for the HTTP response stream parser: item types, codes and scan helpers.
package hrsp_pkg;

   localparam int unsigned MAX_LINE = 512;
   localparam int unsigned LINE_W   = $clog2(MAX_LINE + 2);
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
   localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_BYTE  = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;
   localparam logic [1:0] KIND_CLOSE = 2'd3;

   localparam logic [3:0] PH_IDLE      = 4'd0;
   localparam logic [3:0] PH_STATUS    = 4'd1;
   localparam logic [3:0] PH_HEADER    = 4'd2;
   localparam logic [3:0] PH_CSIZE     = 4'd3;
   localparam logic [3:0] PH_CDATA     = 4'd4;
   localparam logic [3:0] PH_CEND      = 4'd5;
   localparam logic [3:0] PH_TRAILER   = 4'd6;
   localparam logic [3:0] PH_LBODY     = 4'd7;
   localparam logic [3:0] PH_CLOSEBODY = 4'd8;

   localparam logic [1:0] WHICH_NONE    = 2'd0;
   localparam logic [1:0] WHICH_LENGTH  = 2'd1;
   localparam logic [1:0] WHICH_ENCODE  = 2'd2;
   localparam logic [1:0] WHICH_RETRY   = 2'd3;

   localparam logic [1:0] NS_LEAD = 2'd0;
   localparam logic [1:0] NS_SIGN = 2'd1;
   localparam logic [1:0] NS_DIG  = 2'd2;
   localparam logic [1:0] NS_STOP = 2'd3;

   localparam logic [0:0] CSR_MAX_BODY = 1'd0;
   localparam logic [0:0] CSR_TIMEOUT  = 1'd1;

   localparam logic [7:0] CHAR_CR = 8'h0d;
   localparam logic [7:0] CHAR_LF = 8'h0a;

   localparam logic [8*14-1:0] NAME_LENGTH = "content-length";
   localparam logic [8*17-1:0] NAME_ENCODE = "transfer-encoding";
   localparam logic [8*11-1:0] NAME_RETRY  = "retry-after";
   localparam logic [8*7-1:0]  WORD_CHUNKED = "chunked";
   localparam logic [4:0] LEN_LENGTH = 5'd14;
   localparam logic [4:0] LEN_ENCODE = 5'd17;
   localparam logic [4:0] LEN_RETRY  = 5'd11;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
   } req_item_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  body_byte;
      logic        success;
      logic [9:0]  status_code;
      logic        has_length;
      logic [31:0] content_length;
      logic        is_chunked;
      logic        truncated;
      logic [31:0] retry_after_sec;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]  st;
      logic        neg;
      logic        sat;
      logic        pfx;
      logic [31:0] val;
   } num_scan_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   // Returns {valid, digit}.
   function automatic logic [4:0] digit_of(input logic [7:0] c, input logic hex);
      logic [4:0] r;
      r = 5'd0;
      if (c >= "0" && c <= "9") begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (hex && c >= "a" && c <= "f") begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (hex && c >= "A" && c <= "F") begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   // One character into a decimal or hex number scan; saturates at the cap.
   function automatic num_scan_type ns_feed(input num_scan_type s, input logic [7:0] c,
                                            input logic hex);
      num_scan_type r;
      logic [4:0]  d;
      logic [35:0] acc;
      logic [35:0] cap;
      r   = s;
      d   = digit_of(c, hex);
      cap = hex ? 36'h07fffffff : 36'h0ffffffff;
      acc = hex ? ({4'd0, s.val} << 4) : (({4'd0, s.val} << 3) + ({4'd0, s.val} << 1));
      acc = acc + {32'd0, d[3:0]};
      if (s.st == NS_LEAD && is_ws(c)) begin
         r = s;
      end else if (s.st == NS_LEAD && (c == "+" || c == "-")) begin
         r.neg = (c == "-");
         r.st  = NS_SIGN;
      end else if (s.st == NS_LEAD || s.st == NS_SIGN) begin
         if (!d[4]) begin
            r.st = NS_STOP;
         end else begin
            r.st  = NS_DIG;
            r.val = {28'd0, d[3:0]};
            r.pfx = hex && (d[3:0] == 4'd0);
         end
      end else if (s.st == NS_DIG) begin
         r.pfx = 1'b0;
         if (s.pfx && (c == "x" || c == "X")) begin
            r.pfx = 1'b0;
         end else if (!d[4]) begin
            r.st = NS_STOP;
         end else if (acc > cap) begin
            r.val = cap[31:0];
            r.sat = 1'b1;
         end else begin
            r.val = acc[31:0];
         end
      end
      return r;
   endfunction

   function automatic logic [31:0] dec_value(input num_scan_type s);
      logic [31:0] r;
      if (s.sat) begin
         r = 32'hffffffff;
      end else if (s.neg) begin
         r = 32'd0 - s.val;
      end else begin
         r = s.val;
      end
      return r;
   endfunction

   // Character of a header name at a position; zero past its end.
   function automatic logic [7:0] name_char(input logic [1:0] k, input logic [4:0] pos);
      logic [7:0] r;
      r = 8'd0;
      unique case (k)
         2'd0: if (pos < LEN_LENGTH) r = NAME_LENGTH[8*(13 - int'(pos)) +: 8];
         2'd1: if (pos < LEN_ENCODE) r = NAME_ENCODE[8*(16 - int'(pos)) +: 8];
         2'd2: if (pos < LEN_RETRY)  r = NAME_RETRY[8*(10 - int'(pos)) +: 8];
         default: r = 8'd0;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] name_len(input logic [1:0] k);
      logic [4:0] r;
      unique case (k)
         2'd0: r = LEN_LENGTH;
         2'd1: r = LEN_ENCODE;
         2'd2: r = LEN_RETRY;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: sv/http_response_stream_parser.sv
// Top level of the HTTP/1.1 response stream parser with chunked body framing.
// The parser takes one input item per clock: a start marker, one received byte, one time
// tick or a peer-closed marker. Each item is fully decoded in the cycle it is accepted,
// updating the parse state registers, and the one or two result items it causes (a body
// byte and/or a finished report) are written into a four-entry output queue. The input
// side is stalled only while that queue holds more than two items, so with a consumer that
// takes results promptly the block sustains one item per cycle; the queue depth sets how
// much output back-pressure is absorbed before the input stalls. Configuration registers
// (max_body at index 0, timeout_ticks at index 1) are always ready and should be written
// only while no response is in progress.
module http_response_stream_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  hrsp_pkg::req_item_type    req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output hrsp_pkg::rsp_item_type    rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [0:0]                csr_index,
   input  logic [31:0]               csr_wdata
);

   // Configuration.
   logic [15:0] max_body_ff;
   logic [31:0] timeout_ff;

   // Parse state.
   logic [3:0]                     phase_ff, phase_in;
   logic [hrsp_pkg::LINE_W-1:0]    line_len_ff, line_len_in;
   logic                           st_space_ff, st_space_in;
   logic [1:0]                     st_count_ff, st_count_in;
   hrsp_pkg::num_scan_type         st_num_ff, st_num_in;
   logic [9:0]                     code_ff, code_in;
   logic [2:0]                     alive_ff, alive_in;
   logic [4:0]                     pos_ff, pos_in;
   logic [1:0]                     which_ff, which_in;
   logic                           in_value_ff, in_value_in;
   hrsp_pkg::num_scan_type         val_num_ff, val_num_in;
   logic [2:0]                     cpos_ff, cpos_in;
   logic                           any_ff, any_in;
   logic [31:0]                    length_ff, length_in;
   logic [31:0]                    retry_ff, retry_in;
   logic [31:0]                    remain_ff, remain_in;
   logic [15:0]                    kept_ff, kept_in;
   logic [31:0]                    elapsed_ff, elapsed_in;
   logic                           fl_len_ff, fl_len_in;
   logic                           fl_chunk_ff, fl_chunk_in;
   logic                           fl_trunc_ff, fl_trunc_in;

   // Output queue.
   hrsp_pkg::rsp_item_type         queue_ff [hrsp_pkg::FIFO_DEPTH];
   logic [hrsp_pkg::PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [hrsp_pkg::PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [hrsp_pkg::CNT_W-1:0]     count_ff, count_in;

   logic                           req_take;
   logic                           rsp_take;
   logic                           emit_body;
   logic                           emit_fin;
   logic                           fin_ok;
   hrsp_pkg::rsp_item_type         body_item;
   hrsp_pkg::rsp_item_type         fin_item;
   logic [7:0]                     ch;
   logic [7:0]                     lc;
   logic [hrsp_pkg::LINE_W-1:0]    len_next;

   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign req_stall = count_ff > hrsp_pkg::CNT_W'(hrsp_pkg::FIFO_DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = queue_ff[rd_ptr_ff];
   assign csr_ready = 1'b1;
   assign ch        = req_data.data;
   assign lc        = (ch >= "A" && ch <= "Z") ? (ch + 8'd32) : ch;
   assign len_next  = line_len_ff + 1'b1;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_body_ff <= 16'd2048;
         timeout_ff  <= 32'd10000;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            hrsp_pkg::CSR_MAX_BODY: max_body_ff <= csr_wdata[15:0];
            hrsp_pkg::CSR_TIMEOUT:  timeout_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Single-pass decode of the accepted item. Clearing a line is done whenever a line ends;
   // after a finish the stale line state is harmless since a start clears everything.
   always_comb begin
      phase_in    = phase_ff;
      line_len_in = line_len_ff;
      st_space_in = st_space_ff;
      st_count_in = st_count_ff;
      st_num_in   = st_num_ff;
      code_in     = code_ff;
      alive_in    = alive_ff;
      pos_in      = pos_ff;
      which_in    = which_ff;
      in_value_in = in_value_ff;
      val_num_in  = val_num_ff;
      cpos_in     = cpos_ff;
      any_in      = any_ff;
      length_in   = length_ff;
      retry_in    = retry_ff;
      remain_in   = remain_ff;
      kept_in     = kept_ff;
      elapsed_in  = elapsed_ff;
      fl_len_in   = fl_len_ff;
      fl_chunk_in = fl_chunk_ff;
      fl_trunc_in = fl_trunc_ff;
      emit_body   = 1'b0;
      emit_fin    = 1'b0;
      fin_ok      = 1'b0;

      if (req_take) begin
         if (req_data.kind == hrsp_pkg::KIND_START) begin
            phase_in    = hrsp_pkg::PH_STATUS;
            line_len_in = '0;
            st_space_in = 1'b0;
            st_count_in = 2'd0;
            st_num_in   = '0;
            code_in     = 10'd0;
            alive_in    = 3'b111;
            pos_in      = 5'd0;
            which_in    = hrsp_pkg::WHICH_NONE;
            in_value_in = 1'b0;
            val_num_in  = '0;
            cpos_in     = 3'd0;
            any_in      = 1'b0;
            length_in   = 32'd0;
            retry_in    = 32'd0;
            remain_in   = 32'd0;
            kept_in     = 16'd0;
            elapsed_in  = 32'd0;
            fl_len_in   = 1'b0;
            fl_chunk_in = 1'b0;
            fl_trunc_in = 1'b0;
         end else if (phase_ff != hrsp_pkg::PH_IDLE) begin
            unique case (req_data.kind)
               hrsp_pkg::KIND_BYTE: begin
                  if (phase_ff == hrsp_pkg::PH_CDATA || phase_ff == hrsp_pkg::PH_LBODY ||
                      phase_ff == hrsp_pkg::PH_CLOSEBODY) begin
                     if (kept_ff < max_body_ff) begin
                        emit_body = 1'b1;
                        kept_in   = kept_ff + 16'd1;
                     end else begin
                        fl_trunc_in = 1'b1;
                     end
                     if (phase_ff != hrsp_pkg::PH_CLOSEBODY) begin
                        remain_in = remain_ff - 32'd1;
                        if (remain_in == 32'd0) begin
                           if (phase_ff == hrsp_pkg::PH_CDATA) begin
                              phase_in    = hrsp_pkg::PH_CEND;
                              line_len_in = '0;
                              alive_in    = 3'b111;
                              pos_in      = 5'd0;
                              which_in    = hrsp_pkg::WHICH_NONE;
                              in_value_in = 1'b0;
                              val_num_in  = '0;
                              cpos_in     = 3'd0;
                              any_in      = 1'b0;
                           end else begin
                              emit_fin = 1'b1;
                              fin_ok   = 1'b1;
                           end
                        end
                     end
                  end else if (ch == hrsp_pkg::CHAR_CR) begin
                     line_len_in = line_len_ff;
                  end else if (ch == hrsp_pkg::CHAR_LF) begin
                     // End of a line: act on it, then clear the per-line scan state.
                     line_len_in = '0;
                     alive_in    = 3'b111;
                     pos_in      = 5'd0;
                     which_in    = hrsp_pkg::WHICH_NONE;
                     in_value_in = 1'b0;
                     val_num_in  = '0;
                     cpos_in     = 3'd0;
                     any_in      = 1'b0;
                     unique case (phase_ff)
                        hrsp_pkg::PH_STATUS: begin
                           if (!st_space_ff || st_count_ff < 2'd3) begin
                              emit_fin = 1'b1;
                           end else begin
                              if (st_num_ff.neg) begin
                                 code_in = 10'd0;
                              end else if (st_num_ff.val > 32'd999) begin
                                 code_in = 10'd999;
                              end else begin
                                 code_in = st_num_ff.val[9:0];
                              end
                              phase_in = hrsp_pkg::PH_HEADER;
                           end
                        end
                        hrsp_pkg::PH_HEADER: begin
                           if (line_len_ff == '0) begin
                              if (fl_len_ff && length_ff == 32'd0) begin
                                 emit_fin = 1'b1;
                                 fin_ok   = 1'b1;
                              end else if (fl_chunk_ff) begin
                                 phase_in = hrsp_pkg::PH_CSIZE;
                              end else if (fl_len_ff) begin
                                 remain_in = length_ff;
                                 phase_in  = hrsp_pkg::PH_LBODY;
                              end else begin
                                 phase_in = hrsp_pkg::PH_CLOSEBODY;
                              end
                           end else if (in_value_ff) begin
                              if (which_ff == hrsp_pkg::WHICH_LENGTH) begin
                                 fl_len_in = 1'b1;
                                 length_in = hrsp_pkg::dec_value(val_num_ff);
                              end else if (which_ff == hrsp_pkg::WHICH_ENCODE) begin
                                 if (cpos_ff == 3'd7) fl_chunk_in = 1'b1;
                              end else if (which_ff == hrsp_pkg::WHICH_RETRY) begin
                                 retry_in = hrsp_pkg::dec_value(val_num_ff);
                              end
                           end
                        end
                        hrsp_pkg::PH_CSIZE: begin
                           if (any_ff) begin
                              if (val_num_ff.neg && (val_num_ff.val != 32'd0 ||
                                                     val_num_ff.sat)) begin
                                 emit_fin = 1'b1;
                              end else if (val_num_ff.val == 32'd0) begin
                                 phase_in = hrsp_pkg::PH_TRAILER;
                              end else begin
                                 remain_in = val_num_ff.val;
                                 phase_in  = hrsp_pkg::PH_CDATA;
                              end
                           end
                        end
                        hrsp_pkg::PH_CEND: phase_in = hrsp_pkg::PH_CSIZE;
                        hrsp_pkg::PH_TRAILER: begin
                           if (line_len_ff == '0) begin
                              emit_fin = 1'b1;
                              fin_ok   = 1'b1;
                           end
                        end
                        default: ;
                     endcase
                  end else begin
                     line_len_in = len_next;
                     if (len_next > hrsp_pkg::LINE_W'(hrsp_pkg::MAX_LINE)) begin
                        emit_fin = 1'b1;
                        fin_ok   = phase_ff == hrsp_pkg::PH_TRAILER;
                     end else if (phase_ff == hrsp_pkg::PH_STATUS) begin
                        if (!st_space_ff) begin
                           if (ch == 8'h20) begin
                              st_space_in = 1'b1;
                              st_count_in = 2'd0;
                           end
                        end else if (st_count_ff < 2'd3) begin
                           st_num_in   = hrsp_pkg::ns_feed(st_num_ff, ch, 1'b0);
                           st_count_in = st_count_ff + 2'd1;
                        end
                     end else if (phase_ff == hrsp_pkg::PH_HEADER) begin
                        if (!in_value_ff) begin
                           if (ch == ":") begin
                              in_value_in = 1'b1;
                              which_in    = hrsp_pkg::WHICH_NONE;
                              for (int k = 0; k < 3; k++) begin
                                 if (alive_ff[k] && pos_ff == hrsp_pkg::name_len(2'(k))) begin
                                    which_in = 2'(k + 1);
                                 end
                              end
                           end else begin
                              for (int k = 0; k < 3; k++) begin
                                 if (pos_ff >= hrsp_pkg::name_len(2'(k)) ||
                                     hrsp_pkg::name_char(2'(k), pos_ff) != lc) begin
                                    alive_in[k] = 1'b0;
                                 end
                              end
                              if (pos_ff != 5'd31) pos_in = pos_ff + 5'd1;
                           end
                        end else if (which_ff == hrsp_pkg::WHICH_LENGTH ||
                                     which_ff == hrsp_pkg::WHICH_RETRY) begin
                           val_num_in = hrsp_pkg::ns_feed(val_num_ff, ch, 1'b0);
                        end else if (which_ff == hrsp_pkg::WHICH_ENCODE && cpos_ff < 3'd7) begin
                           if (ch == hrsp_pkg::WORD_CHUNKED[8*(6 - int'(cpos_ff)) +: 8]) begin
                              cpos_in = cpos_ff + 3'd1;
                           end else begin
                              cpos_in = (ch == "c") ? 3'd1 : 3'd0;
                           end
                        end
                     end else if (phase_ff == hrsp_pkg::PH_CSIZE) begin
                        if (!hrsp_pkg::is_ws(ch)) any_in = 1'b1;
                        val_num_in = hrsp_pkg::ns_feed(val_num_ff, ch, 1'b1);
                     end
                  end
               end
               hrsp_pkg::KIND_TICK: begin
                  if (elapsed_ff != 32'hffffffff) elapsed_in = elapsed_ff + 32'd1;
                  if (elapsed_in >= timeout_ff) begin
                     emit_fin = 1'b1;
                     fin_ok   = phase_ff == hrsp_pkg::PH_TRAILER;
                  end
               end
               hrsp_pkg::KIND_CLOSE: begin
                  emit_fin = 1'b1;
                  fin_ok   = (phase_ff == hrsp_pkg::PH_CLOSEBODY) ||
                             (phase_ff == hrsp_pkg::PH_TRAILER) ||
                             (phase_ff == hrsp_pkg::PH_CSIZE && line_len_ff != '0 && any_ff &&
                              val_num_ff.val == 32'd0);
               end
               default: ;
            endcase
         end
      end
      if (emit_fin) phase_in = hrsp_pkg::PH_IDLE;
   end

   // Result items. The report carries the state as it stands after this item.
   always_comb begin
      body_item             = '0;
      body_item.result_kind = 1'b0;
      body_item.body_byte   = ch;
      body_item.last        = !emit_fin;

      fin_item                 = '0;
      fin_item.result_kind     = 1'b1;
      fin_item.success         = fin_ok;
      fin_item.status_code     = code_in;
      fin_item.has_length      = fl_len_in;
      fin_item.content_length  = length_in;
      fin_item.is_chunked      = fl_chunk_in;
      fin_item.truncated       = fl_trunc_in;
      fin_item.retry_after_sec = retry_in;
      fin_item.last            = 1'b1;
   end

   // Queue pointers.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + hrsp_pkg::PTR_W'(emit_body) + hrsp_pkg::PTR_W'(emit_fin);
      rd_ptr_in = rd_ptr_ff + hrsp_pkg::PTR_W'(rsp_take);
      count_in  = count_ff + hrsp_pkg::CNT_W'(emit_body) + hrsp_pkg::CNT_W'(emit_fin) -
                  hrsp_pkg::CNT_W'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (emit_body) begin
         queue_ff[wr_ptr_ff] <= body_item;
      end
      if (emit_fin) begin
         queue_ff[wr_ptr_ff + hrsp_pkg::PTR_W'(emit_body)] <= fin_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= hrsp_pkg::PH_IDLE;
         line_len_ff <= '0;
         st_space_ff <= 1'b0;
         st_count_ff <= 2'd0;
         st_num_ff   <= '0;
         code_ff     <= 10'd0;
         alive_ff    <= 3'b111;
         pos_ff      <= 5'd0;
         which_ff    <= hrsp_pkg::WHICH_NONE;
         in_value_ff <= 1'b0;
         val_num_ff  <= '0;
         cpos_ff     <= 3'd0;
         any_ff      <= 1'b0;
         length_ff   <= 32'd0;
         retry_ff    <= 32'd0;
         remain_ff   <= 32'd0;
         kept_ff     <= 16'd0;
         elapsed_ff  <= 32'd0;
         fl_len_ff   <= 1'b0;
         fl_chunk_ff <= 1'b0;
         fl_trunc_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         phase_ff    <= phase_in;
         line_len_ff <= line_len_in;
         st_space_ff <= st_space_in;
         st_count_ff <= st_count_in;
         st_num_ff   <= st_num_in;
         code_ff     <= code_in;
         alive_ff    <= alive_in;
         pos_ff      <= pos_in;
         which_ff    <= which_in;
         in_value_ff <= in_value_in;
         val_num_ff  <= val_num_in;
         cpos_ff     <= cpos_in;
         any_ff      <= any_in;
         length_ff   <= length_in;
         retry_ff    <= retry_in;
         remain_ff   <= remain_in;
         kept_ff     <= kept_in;
         elapsed_ff  <= elapsed_in;
         fl_len_ff   <= fl_len_in;
         fl_chunk_ff <= fl_chunk_in;
         fl_trunc_ff <= fl_trunc_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
   end

   // The queue never holds more items than it has entries.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= hrsp_pkg::CNT_W'(hrsp_pkg::FIFO_DEPTH))
      else $error("output queue overfilled");

   // A finished report is always the last result of its input item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind |-> rsp_data.last)
      else $error("finished report without last");

   // Once a response finishes, the parser goes idle.
   assert property (@(posedge clock) disable iff (reset)
      emit_fin |=> phase_ff == hrsp_pkg::PH_IDLE)
      else $error("parser not idle after finish");

   // Body bytes are never passed on beyond the configured limit.
   assert property (@(posedge clock) disable iff (reset)
      emit_body |-> kept_ff < max_body_ff)
      else $error("body byte passed beyond max_body");

endmodule
